### hw/rtl/assert_macros.svh
// Assertion macros used by the RTL file of the keyed table core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define KT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("keyed table assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define KT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keyed table assertion failed");

`endif

### hw/rtl/ktsd_pkg.sv
// Package of the keyed table: sizes, operation and status codes, entry and control types.
package ktsd_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int KEY_W = 31;
  localparam int VAL_W = 32;
  localparam int FUNC_W = 2;
  localparam int STAT_W = 3;

  localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FN_SEARCH = 2'd1;
  localparam logic [FUNC_W-1:0] FN_UPDATE = 2'd2;
  localparam logic [FUNC_W-1:0] FN_DUMP   = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 3'd1;
  localparam logic [STAT_W-1:0] ST_DUP   = 3'd2;
  localparam logic [STAT_W-1:0] ST_MISS  = 3'd3;
  localparam logic [STAT_W-1:0] ST_EMPTY = 3'd4;

  typedef struct packed {
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] count;
  } entry_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic rot;  // shift the ring one place toward the head
    logic ins;  // open a slot at the sorted position and drop the new entry in
  } cell_ctl_t;

  // Adds two signed counts and clamps the result to the signed range.
  function automatic logic signed [VAL_W-1:0] sat_add(
    input logic signed [VAL_W-1:0] a,
    input logic signed [VAL_W-1:0] b
  );
    logic signed [VAL_W:0] sum;
    logic signed [VAL_W-1:0] res;
    sum = {a[VAL_W-1], a} + {b[VAL_W-1], b};
    if (sum[VAL_W] != sum[VAL_W-1]) begin
      res = sum[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end else begin
      res = sum[VAL_W-1:0];
    end
    return res;
  endfunction

endpackage

### hw/rtl/ktsd_cell.sv
// One cell of the sorted entry chain: holds a key and its count.
module ktsd_cell (
  input  logic               clk,
  input  ktsd_pkg::cell_ctl_t ctl,
  input  logic               occ,
  input  ktsd_pkg::entry_t   rot_in,
  input  ktsd_pkg::entry_t   left_in,
  input  ktsd_pkg::entry_t   new_in,
  input  logic               gt_left,
  output ktsd_pkg::entry_t   ent,
  output logic               gt
);
  import ktsd_pkg::*;

  entry_t ent_r;
  entry_t ent_nxt;

  // An empty cell, or one with a larger key, lies at or past the insertion point.
  assign gt  = !occ || (ent_r.key > new_in.key);
  assign ent = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (ctl.rot) begin
      ent_nxt = rot_in;
    end else if (ctl.ins) begin
      if (gt_left) begin
        ent_nxt = left_in;
      end else if (gt) begin
        ent_nxt = new_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

### hw/rtl/keyed_table_with_sorted_dump_core.sv
// Top level of the keyed table: a ring of entry cells kept in ascending key order.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+----------------------------------------
//   in      | to core   | in_valid / in_stall | in_func, in_key, in_amount
//   out     | from core | out_valid/out_stall | out_status, out_key, out_count, out_last
//
// Search, update and insert rotate the ring once past the head for a key match; a stored
// insert then takes the sorted insert step. A full-table insert or an empty dump answers
// without a rotation. A dump rotates the ring once, held still while a live head entry
// waits on a stalled output. Every entry passes the single head cell, a cell a cycle.
// Reset (synchronous, active low) clears the entry count and the control; cells hold none.
// An output stall freezes a dump at the head or holds a single result; input waits for idle.
module keyed_table_with_sorted_dump_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [ktsd_pkg::FUNC_W-1:0]          in_func,
  input  logic [ktsd_pkg::KEY_W-1:0]           in_key,
  input  logic signed [ktsd_pkg::VAL_W-1:0]    in_amount,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [ktsd_pkg::STAT_W-1:0]          out_status,
  output logic [ktsd_pkg::KEY_W-1:0]           out_key,
  output logic signed [ktsd_pkg::VAL_W-1:0]    out_count,
  output logic                                 out_last
);
  import ktsd_pkg::*;
  `include "assert_macros.svh"

  // Controller states.
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for an input beat
  localparam logic [2:0] S_SCAN = 3'd1;  // rotating the ring past the head for a key match
  localparam logic [2:0] S_INS  = 3'd2;  // sorted insert step into the chain
  localparam logic [2:0] S_DUMP = 3'd3;  // rotating the ring and emitting each entry
  localparam logic [2:0] S_RESP = 3'd4;  // single result waiting for the output register

  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(DEPTH - 1);

  logic [2:0]              state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [IDX_W-1:0]        step_r, step_nxt;
  logic [FUNC_W-1:0]       q_func_r, q_func_nxt;
  logic [KEY_W-1:0]        q_key_r, q_key_nxt;
  logic signed [VAL_W-1:0] q_amt_r, q_amt_nxt;
  logic                    hit_r, hit_nxt;
  logic signed [VAL_W-1:0] hit_cnt_r, hit_cnt_nxt;
  logic [STAT_W-1:0]       res_status_r, res_status_nxt;
  logic signed [VAL_W-1:0] res_cnt_r, res_cnt_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]       out_status_r, out_status_nxt;
  logic [KEY_W-1:0]        out_key_r, out_key_nxt;
  logic signed [VAL_W-1:0] out_count_r, out_count_nxt;
  logic                    out_last_r, out_last_nxt;

  cell_ctl_t               ctl;
  entry_t                  ent [DEPTH];
  logic                    gt [DEPTH];
  entry_t                  new_ent;
  entry_t                  tail_ent;
  logic                    head_occ;
  logic                    match;
  logic                    hit_now;
  logic signed [VAL_W-1:0] upd_cnt;
  logic signed [VAL_W-1:0] match_cnt;
  logic signed [VAL_W-1:0] hit_cnt_now;
  logic                    out_free;
  logic                    dump_adv;

  // The entry at the head during a rotation is the one stored at index step_r
  // when the ring was at rest, so it is live exactly when step_r is below the count.
  assign head_occ  = CNT_W'(step_r) < cnt_r;
  assign match     = head_occ && (ent[0].key == q_key_r);
  assign upd_cnt   = sat_add(ent[0].count, q_amt_r);
  assign match_cnt = (q_func_r == FN_UPDATE) ? upd_cnt : ent[0].count;
  assign hit_now   = hit_r || match;
  assign hit_cnt_now = match ? match_cnt : hit_cnt_r;

  // An update writes the new count back as the entry leaves the head for the tail.
  assign tail_ent.key   = ent[0].key;
  assign tail_ent.count = (match && (q_func_r == FN_UPDATE)) ? upd_cnt : ent[0].count;

  assign new_ent.key   = q_key_r;
  assign new_ent.count = q_amt_r;

  assign out_free = !out_valid_r || !out_stall;
  // A dump holds the ring still while a live head entry cannot be handed out.
  assign dump_adv = !head_occ || out_free;

  assign ctl.rot = (state_r == S_SCAN) || ((state_r == S_DUMP) && dump_adv);
  assign ctl.ins = (state_r == S_INS);

  // The chain: each cell takes its right neighbor on a rotation and its left
  // neighbor when an insert opens a slot; the last cell closes the ring.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t rot_src;
    entry_t left_src;
    logic   gt_src;
    if (i == DEPTH - 1) begin : g_tail
      assign rot_src = tail_ent;
    end else begin : g_mid
      assign rot_src = ent[i+1];
    end
    if (i == 0) begin : g_head
      assign left_src = new_ent;
      assign gt_src   = 1'b0;
    end else begin : g_body
      assign left_src = ent[i-1];
      assign gt_src   = gt[i-1];
    end
    ktsd_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .occ     (CNT_W'(i) < cnt_r),
      .rot_in  (rot_src),
      .left_in (left_src),
      .new_in  (new_ent),
      .gt_left (gt_src),
      .ent     (ent[i]),
      .gt      (gt[i])
    );
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    step_nxt       = step_r;
    q_func_nxt     = q_func_r;
    q_key_nxt      = q_key_r;
    q_amt_nxt      = q_amt_r;
    hit_nxt        = hit_r;
    hit_cnt_nxt    = hit_cnt_r;
    res_status_nxt = res_status_r;
    res_cnt_nxt    = res_cnt_r;

    // The output register drops its beat once taken and is reloaded below.
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_key_nxt    = out_key_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          q_func_nxt  = in_func;
          q_key_nxt   = in_key;
          q_amt_nxt   = in_amount;
          hit_nxt     = 1'b0;
          hit_cnt_nxt = '0;
          step_nxt    = '0;
          if ((in_func == FN_INSERT) && (cnt_r == CNT_W'(DEPTH))) begin
            // A full table refuses the insert before any key check.
            res_status_nxt = ST_FULL;
            res_cnt_nxt    = '0;
            state_nxt      = S_RESP;
          end else if (in_func == FN_DUMP) begin
            if (cnt_r == '0) begin
              // An empty table answers a dump with one empty beat.
              q_key_nxt      = '0;
              res_status_nxt = ST_EMPTY;
              res_cnt_nxt    = '0;
              state_nxt      = S_RESP;
            end else begin
              state_nxt = S_DUMP;
            end
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (match) begin
          hit_nxt     = 1'b1;
          hit_cnt_nxt = match_cnt;
        end
        if (step_r == LAST_STEP) begin
          step_nxt = '0;
          if (q_func_r == FN_INSERT) begin
            if (hit_now) begin
              res_status_nxt = ST_DUP;
              res_cnt_nxt    = hit_cnt_now;
              state_nxt      = S_RESP;
            end else begin
              state_nxt = S_INS;
            end
          end else begin
            res_status_nxt = hit_now ? ST_OK : ST_MISS;
            res_cnt_nxt    = hit_now ? hit_cnt_now : '0;
            state_nxt      = S_RESP;
          end
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_INS: begin
        cnt_nxt        = cnt_r + 1'b1;
        res_status_nxt = ST_OK;
        res_cnt_nxt    = q_amt_r;
        state_nxt      = S_RESP;
      end
      S_DUMP: begin
        if (head_occ && out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_key_nxt    = ent[0].key;
          out_count_nxt  = ent[0].count;
          out_last_nxt   = (CNT_W'(step_r) + CNT_W'(1)) == cnt_r;
        end
        if (dump_adv) begin
          if (step_r == LAST_STEP) begin
            step_nxt  = '0;
            state_nxt = S_IDLE;
          end else begin
            step_nxt = step_r + 1'b1;
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_key_nxt    = q_key_r;
          out_count_nxt  = res_cnt_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        step_nxt  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_func_r     <= q_func_nxt;
    q_key_r      <= q_key_nxt;
    q_amt_r      <= q_amt_nxt;
    hit_r        <= hit_nxt;
    hit_cnt_r    <= hit_cnt_nxt;
    res_status_r <= res_status_nxt;
    res_cnt_r    <= res_cnt_nxt;
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_key    = out_key_r;
  assign out_count  = out_count_r;
  assign out_last   = out_last_r;

  // The entry count never passes the number of cells.
  `KT_ASSERT_IMP(a_cnt_range, 1'b1, cnt_r <= CNT_W'(DEPTH))
  // Only the insert step changes the entry count.
  `KT_ASSERT_NXT(a_cnt_hold, state_r != S_INS, $stable(cnt_r))
  // Every rotation returns the ring to rest, so an idle block sits at step zero.
  `KT_ASSERT_IMP(a_idle_step, state_r == S_IDLE, step_r == '0)
  // An empty-table beat is always a final beat with zero key and count.
  `KT_ASSERT_IMP(a_empty_beat, out_valid_r && (out_status_r == ST_EMPTY),
                 out_last_r && (out_key_r == '0) && (out_count_r == '0))

endmodule

### tb/keyed_table_with_sorted_dump_core_tb.sv
// Self-checking testbench for the keyed table core: directed and random commands.
module keyed_table_with_sorted_dump_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ktsd_pkg::*;

  // The pass point below is reached long before this in any healthy run. The worst
  // correct run is about 190 commands, each a dump of 64 entries whose every beat
  // waits out the longest stall, plus one long hold-off.
  localparam int LIMIT_CYCLES = 4_000_000;
  localparam int RANDOM_ITEMS = 90;
  // Long enough that a dump freezes at the head and the commands behind it back up.
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE_CYCLES = 3 * DEPTH;
  localparam logic [KEY_W-1:0] KEY_TOP = {KEY_W{1'b1}};
  localparam logic signed [VAL_W-1:0] COUNT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] COUNT_MIN = 32'sh8000_0000;

  // One beat that the core is expected to put on its result channel.
  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] count;
    logic                    last;
  } answer_t;

  // Mirror of the table: entries kept in arrival order, unlike the sorted storage they model.
  class keyed_table_checker;
    logic [KEY_W-1:0]        keys[DEPTH];
    logic signed [VAL_W-1:0] counts[DEPTH];
    int                      filled;
    int                      errors;
    answer_t                 answers_due[$];

    function new();
      filled = 0;
      errors = 0;
    endfunction

    function int pending();
      return answers_due.size();
    endfunction

    function int find(input logic [KEY_W-1:0] key);
      int i;
      for (i = 0; i < filled; i++) begin
        if (keys[i] == key) return i;
      end
      return -1;
    endfunction

    function void owe(input logic [STAT_W-1:0] status, input logic [KEY_W-1:0] key,
                      input logic signed [VAL_W-1:0] count, input logic last);
      answer_t a;
      a.status = status;
      a.key    = key;
      a.count  = count;
      a.last   = last;
      answers_due.push_back(a);
    endfunction

    // Called for every command beat the core accepts; queues the answers it owes.
    function void take_command(input logic [FUNC_W-1:0] func, input logic [KEY_W-1:0] key,
                               input logic signed [VAL_W-1:0] amount);
      int idx;
      int i;
      int n;
      int best;
      longint total;
      logic [KEY_W-1:0] floor_key;
      bit have_floor;
      case (func)
        FN_INSERT: begin
          // A full table refuses before it looks for the key.
          if (filled >= DEPTH) begin
            owe(ST_FULL, key, '0, 1'b1);
          end else begin
            idx = find(key);
            if (idx >= 0) begin
              owe(ST_DUP, key, counts[idx], 1'b1);
            end else begin
              keys[filled]   = key;
              counts[filled] = amount;
              filled++;
              owe(ST_OK, key, amount, 1'b1);
            end
          end
        end
        FN_SEARCH, FN_UPDATE: begin
          idx = find(key);
          if (idx < 0) begin
            owe(ST_MISS, key, '0, 1'b1);
          end else begin
            if (func == FN_UPDATE) begin
              total = longint'(counts[idx]) + longint'(amount);
              if (total > longint'(COUNT_MAX)) total = longint'(COUNT_MAX);
              if (total < longint'(COUNT_MIN)) total = longint'(COUNT_MIN);
              counts[idx] = total[VAL_W-1:0];
            end
            owe(ST_OK, key, counts[idx], 1'b1);
          end
        end
        default: begin
          if (filled == 0) begin
            owe(ST_EMPTY, '0, '0, 1'b1);
          end else begin
            // Pick the smallest key above the previous one, once per entry.
            have_floor = 1'b0;
            floor_key  = '0;
            for (n = 0; n < filled; n++) begin
              best = -1;
              for (i = 0; i < filled; i++) begin
                if (have_floor && keys[i] <= floor_key) continue;
                if (best < 0 || keys[i] < keys[best]) best = i;
              end
              owe(ST_OK, keys[best], counts[best], n == filled - 1);
              floor_key  = keys[best];
              have_floor = 1'b1;
            end
          end
        end
      endcase
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= 100) $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    // Called for every result beat taken from the core.
    task check_answer(input logic [STAT_W-1:0] status, input logic [KEY_W-1:0] key,
                      input logic signed [VAL_W-1:0] count, input logic last);
      answer_t want;
      if (answers_due.size() == 0) begin
        report($sformatf("result with nothing pending: status %0d key %h count %h",
                         status, key, count));
        return;
      end
      want = answers_due.pop_front();
      if (status !== want.status)
        report($sformatf("status %0d, expected %0d (key %h)", status, want.status, want.key));
      if (key !== want.key)
        report($sformatf("key %h, expected %h", key, want.key));
      if (count !== want.count)
        report($sformatf("count %h, expected %h (key %h)", count, want.count, want.key));
      if (last !== want.last)
        report($sformatf("last %b, expected %b (key %h)", last, want.last, want.key));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [FUNC_W-1:0] in_func;
  logic [KEY_W-1:0] in_key;
  logic signed [VAL_W-1:0] in_amount;
  logic out_valid;
  logic out_stall;
  logic [STAT_W-1:0] out_status;
  logic [KEY_W-1:0] out_key;
  logic signed [VAL_W-1:0] out_count;
  logic out_last;

  keyed_table_checker sb = new();

  // Set by the stimulus to ask the receiver for one long hold-off.
  bit hold_off_req = 1'b0;
  // Every key that was ever offered for insert, so later commands can hit the table.
  logic [KEY_W-1:0] key_pool[$];
  int cycles = 0;

  keyed_table_with_sorted_dump_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_func    (in_func),
    .in_key     (in_key),
    .in_amount  (in_amount),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_status (out_status),
    .out_key    (out_key),
    .out_count  (out_count),
    .out_last   (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: a hung core or a lost result ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result monitor. Sampling at the rising edge sees the values that the core held
  // through the edge, and out_stall only moves on falling edges.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_answer(out_status, out_key, out_count, out_last);
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Receiver. Alternates free and stalled stretches; a free stretch is sometimes long
  // so whole dumps stream out unhindered. One assignment to out_stall per cycle.
  initial begin : receiver
    int phase_left;
    int hold_left;
    bit stalling;
    out_stall  = 1'b0;
    phase_left = 0;
    hold_left  = 0;
    stalling   = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        if (phase_left == 0) begin
          stalling = !stalling;
          if (stalling)
            phase_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                     : $urandom_range(1, 3);
          else
            phase_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 120)
                                                     : $urandom_range(1, 8);
        end
        out_stall <= stalling;
        phase_left--;
      end
    end
  end

  // Offers one command beat and returns on the falling edge after it was taken.
  // Must be entered on a falling edge; valid stays high for a back-to-back beat.
  task automatic send_command(input logic [FUNC_W-1:0] func, input logic [KEY_W-1:0] key,
                              input logic signed [VAL_W-1:0] amount);
    in_valid  <= 1'b1;
    in_func   <= func;
    in_key    <= key;
    in_amount <= amount;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.take_command(func, key, amount);
    if (func == FN_INSERT) key_pool.push_back(key);
    @(negedge clk);
  endtask

  task automatic pause_sender(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Sender goes quiet until every owed result has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  function automatic logic [KEY_W-1:0] fresh_key();
    case ($urandom_range(0, 3))
      0:       return KEY_W'($urandom_range(0, 63));
      1:       return KEY_TOP - KEY_W'($urandom_range(0, 63));
      default: return KEY_W'($urandom);
    endcase
  endfunction

  // Most commands aim at keys already offered, so hits, duplicates and updates happen.
  function automatic logic [KEY_W-1:0] pick_key();
    if (key_pool.size() != 0 && $urandom_range(0, 9) < 7)
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    return fresh_key();
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_amount();
    case ($urandom_range(0, 9))
      0:       return COUNT_MAX;
      1:       return COUNT_MIN;
      2, 3:    return VAL_W'($urandom_range(0, 200)) - 32'sd100;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // Inserts dominate until the table is full; after that the mix leans to updates.
  function automatic logic [FUNC_W-1:0] pick_func();
    int r;
    r = $urandom_range(0, 99);
    if (sb.filled < DEPTH) begin
      if (r < 45) return FN_INSERT;
      if (r < 65) return FN_SEARCH;
      if (r < 90) return FN_UPDATE;
      return FN_DUMP;
    end
    if (r < 15) return FN_INSERT;
    if (r < 50) return FN_SEARCH;
    if (r < 90) return FN_UPDATE;
    return FN_DUMP;
  endfunction

  task automatic send_random();
    send_command(pick_func(), pick_key(), pick_amount());
  endtask

  task automatic feed(input logic [FUNC_W-1:0] func, input logic [KEY_W-1:0] key,
                      input logic signed [VAL_W-1:0] amount);
    send_command(func, key, amount);
    pause_sender(gap_len());
  endtask

  // Backs the core up: the receiver holds off while a dump and a string of commands
  // are offered without gaps, so the dump freezes at the head and the input stalls.
  task automatic back_up_core();
    int k;
    drain();
    hold_off_req = 1'b1;
    send_command(FN_DUMP, KEY_W'($urandom), VAL_W'($urandom));
    for (k = 0; k < 8; k++) send_random();
    pause_sender(1);
  endtask

  initial begin : stimulus
    int n;
    int burst_left;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_func   = FN_SEARCH;
    in_key    = '0;
    in_amount = '0;
    burst_left = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. An empty table first: a dump reports empty, lookups miss.
    feed(FN_DUMP, KEY_TOP, COUNT_MIN);
    feed(FN_SEARCH, 31'd5, 32'sd0);
    feed(FN_UPDATE, KEY_TOP, 32'sd1);
    // Four entries at the key and count extremes, inserted out of key order.
    feed(FN_INSERT, '0, COUNT_MAX);
    feed(FN_INSERT, KEY_TOP, COUNT_MIN);
    feed(FN_INSERT, 31'h5555_5555, -32'sd1);
    feed(FN_INSERT, 31'h2AAA_AAAA, 32'sd1);
    // A duplicate insert reports the stored count and changes nothing.
    feed(FN_INSERT, '0, 32'sd7);
    feed(FN_SEARCH, '0, 32'sd0);
    // Saturation at both ends, and an increment of exactly one that must apply.
    feed(FN_UPDATE, '0, 32'sd1);
    feed(FN_UPDATE, KEY_TOP, -32'sd1);
    feed(FN_UPDATE, 31'h2AAA_AAAA, 32'sd1);
    feed(FN_UPDATE, 31'h5555_5555, COUNT_MIN);
    feed(FN_UPDATE, '0, COUNT_MIN);
    feed(FN_UPDATE, KEY_TOP, COUNT_MAX);
    feed(FN_SEARCH, 31'h5555_5555, 32'sd0);
    feed(FN_SEARCH, 31'h1234_5678, 32'sd0);
    feed(FN_UPDATE, 31'h1234_5678, 32'sd9);
    feed(FN_DUMP, '0, 32'sd0);
    drain();

    // Random part, with occasional bursts that offer a beat every cycle.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) back_up_core();
      send_random();
      if (burst_left > 0) begin
        burst_left--;
      end else if ($urandom_range(0, 19) == 0) begin
        burst_left = $urandom_range(10, 30);
      end else begin
        pause_sender(gap_len());
      end
    end

    // Make sure the table ends up full, then send inserts it refuses, an update, a search and a full dump.
    while (sb.filled < DEPTH) feed(FN_INSERT, fresh_key(), pick_amount());
    feed(FN_INSERT, pick_key(), pick_amount());
    feed(FN_INSERT, fresh_key(), pick_amount());
    feed(FN_UPDATE, pick_key(), pick_amount());
    feed(FN_SEARCH, pick_key(), pick_amount());
    feed(FN_DUMP, pick_key(), pick_amount());

    drain();
    // Anything the core still emits after this is unexpected and gets flagged.
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
